// ===== hw/rtl/bayer_bilinear_demosaic_top_defines.svh =====
// Assertion macros for the bilinear demosaic block.
`ifndef BAYER_BILINEAR_DEMOSAIC_TOP_DEFINES_SVH
`define BAYER_BILINEAR_DEMOSAIC_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define BBD_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("bbd assertion failed");
`define BBD_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("bbd forbidden condition seen");
`else
`define BBD_ASSERT(lbl, clk, rstn, prop)
`define BBD_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

// ===== hw/rtl/bbd_pkg.sv =====
// Types, constants and helpers shared by the demosaic block.
package bbd_pkg;

  localparam int MaxLineWidth = 4096;
  localparam int SampleBits   = 16;
  localparam int AddrW        = $clog2(MaxLineWidth);
  localparam int WidthW       = 13;
  localparam int HeightW      = 16;
  localparam int CfgIdxW      = 2;
  localparam int CfgDataW     = 16;
  localparam int QDepth       = 8;
  localparam int QPtrW        = $clog2(QDepth);
  localparam int QCntW        = $clog2(QDepth + 1);

  localparam logic [CfgIdxW-1:0] RegPattern     = 2'd0;
  localparam logic [CfgIdxW-1:0] RegLineWidth   = 2'd1;
  localparam logic [CfgIdxW-1:0] RegFrameHeight = 2'd2;

  localparam logic [WidthW-1:0]  LineWidthRst   = 13'd4096;
  localparam logic [HeightW-1:0] FrameHeightRst = 16'd1080;

  typedef enum logic [1:0] {
    PH_RED,
    PH_BLUE,
    PH_GR_RROW,
    PH_GR_BROW
  } phase_e;

  typedef struct packed {
    logic [1:0]         pattern;
    logic [WidthW-1:0]  line_width;
    logic [HeightW-1:0] frame_height;
  } cfg_t;

  typedef struct packed {
    logic [SampleBits-1:0] ctr;
    logic [SampleBits-1:0] hor;
    logic [SampleBits-1:0] ver;
    logic [SampleBits-1:0] plus;
    logic [SampleBits-1:0] diag;
    phase_e                phase;
    logic                  row_end;
  } pix_entry_t;

  typedef struct packed {
    logic [AddrW-1:0] col;
  } front_status_t;

  function automatic logic [AddrW:0] eff_width(logic [WidthW-1:0] w);
    logic [AddrW:0] res;
    if (w < WidthW'(3)) begin
      res = (AddrW+1)'(3);
    end else if (32'(w) > MaxLineWidth) begin
      res = (AddrW+1)'(MaxLineWidth);
    end else begin
      res = (AddrW+1)'(w);
    end
    return res;
  endfunction

  function automatic logic [HeightW-1:0] eff_height(logic [HeightW-1:0] h);
    return (h < HeightW'(3)) ? HeightW'(3) : h;
  endfunction

endpackage

// ===== hw/rtl/bbd_line_buf.sv =====
// Two line stores with registered read and upper-line write forwarding.
module bbd_line_buf import bbd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  rd_en_i,
  input  logic [AddrW-1:0]      addr_i,
  input  logic [SampleBits-1:0] sample_i,
  input  logic                  up_we_i,
  input  logic [AddrW-1:0]      up_addr_i,
  output logic [SampleBits-1:0] up_o,
  output logic [SampleBits-1:0] mid_o
);

  logic [SampleBits-1:0] upper_mem [MaxLineWidth];
  logic [SampleBits-1:0] middle_mem [MaxLineWidth];
  logic [SampleBits-1:0] up_rd_q, mid_rd_q, fwd_data_q;
  logic                  fwd_q;

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      up_rd_q          <= upper_mem[addr_i];
      mid_rd_q         <= middle_mem[addr_i];
      middle_mem[addr_i] <= sample_i;
    end
    if (up_we_i) begin
      upper_mem[up_addr_i] <= mid_rd_q;
    end
    fwd_data_q <= mid_rd_q;
  end

  // read and write of the same upper entry in one cycle: take the new data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (rd_en_i) begin
      fwd_q <= up_we_i && (addr_i == up_addr_i);
    end
  end

  assign up_o  = fwd_q ? fwd_data_q : up_rd_q;
  assign mid_o = mid_rd_q;

endmodule

// ===== hw/rtl/bbd_front.sv =====
// Front end: raster counters, line stores, 3x3 window and neighbour means.
module bbd_front import bbd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cfg_t                  cfg_i,
  input  logic                  in_valid_i,
  input  logic [SampleBits-1:0] raw_sample_i,
  input  logic                  frame_start_i,
  output logic                  in_stall_o,
  input  logic [QCntW-1:0]      q_count_i,
  output logic                  push_o,
  output pix_entry_t            entry_o,
  output front_status_t         status_o
);

  logic [AddrW-1:0]   col_q, col_d, c_cur;
  logic [HeightW-1:0] row_q, row_d, r_cur;
  logic [AddrW:0]     w_eff, c_inc;
  logic [HeightW-1:0] h_eff;
  logic               acc, emit0, row_end0;
  phase_e             phase0;

  logic                  v1_q, emit1_q, re1_q;
  logic [SampleBits-1:0] s1_q;
  logic [AddrW-1:0]      c1_q;
  phase_e                ph1_q;

  logic   v2_q, re2_q;
  phase_e ph2_q;
  logic [SampleBits-1:0] win_q [9];

  logic [SampleBits-1:0] up_w, mid_w;
  logic [SampleBits:0]   hor_sum, ver_sum;
  logic [SampleBits+1:0] plus_sum, diag_sum;
  logic [QCntW+1:0]      occupancy;

  assign w_eff = eff_width(cfg_i.line_width);
  assign h_eff = eff_height(cfg_i.frame_height);

  assign occupancy  = (QCntW+2)'(q_count_i) + (QCntW+2)'(v1_q) + (QCntW+2)'(v2_q);
  assign in_stall_o = occupancy >= (QCntW+2)'(QDepth);
  assign acc        = in_valid_i & ~in_stall_o;

  always_comb begin
    c_cur = frame_start_i ? '0 : col_q;
    r_cur = frame_start_i ? '0 : row_q;
    if ({1'b0, c_cur} >= w_eff) begin
      c_cur = '0;
      r_cur = r_cur + HeightW'(1);
    end
    if (r_cur >= h_eff) begin
      r_cur = '0;
    end
    c_inc = {1'b0, c_cur} + (AddrW+1)'(1);
    if (c_inc >= w_eff) begin
      col_d = '0;
      row_d = ((HeightW+1)'(r_cur) + (HeightW+1)'(1) >= (HeightW+1)'(h_eff)) ?
              '0 : r_cur + HeightW'(1);
    end else begin
      col_d = c_inc[AddrW-1:0];
      row_d = r_cur;
    end
  end

  always_comb begin
    emit0    = (r_cur >= HeightW'(2)) && (c_cur >= AddrW'(2));
    row_end0 = (c_inc == w_eff);
    unique case ({~r_cur[0] == cfg_i.pattern[1], c_cur[0] == cfg_i.pattern[0]})
      2'b11:   phase0 = PH_RED;
      2'b00:   phase0 = PH_BLUE;
      2'b10:   phase0 = PH_GR_RROW;
      default: phase0 = PH_GR_BROW;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      for (int i = 0; i < 9; i++) win_q[i] <= '0;
    end else begin
      if (acc) begin
        col_q <= col_d;
        row_q <= row_d;
      end
      v1_q <= acc;
      v2_q <= v1_q & emit1_q;
      if (v1_q) begin
        win_q[0] <= win_q[1];
        win_q[1] <= win_q[2];
        win_q[2] <= up_w;
        win_q[3] <= win_q[4];
        win_q[4] <= win_q[5];
        win_q[5] <= mid_w;
        win_q[6] <= win_q[7];
        win_q[7] <= win_q[8];
        win_q[8] <= s1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_q    <= raw_sample_i;
      c1_q    <= c_cur;
      emit1_q <= emit0;
      re1_q   <= row_end0;
      ph1_q   <= phase0;
    end
    if (v1_q) begin
      re2_q <= re1_q;
      ph2_q <= ph1_q;
    end
  end

  bbd_line_buf u_line_buf (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (acc),
    .addr_i    (c_cur),
    .sample_i  (raw_sample_i),
    .up_we_i   (v1_q),
    .up_addr_i (c1_q),
    .up_o      (up_w),
    .mid_o     (mid_w)
  );

  assign hor_sum  = (SampleBits+1)'(win_q[3]) + (SampleBits+1)'(win_q[5]);
  assign ver_sum  = (SampleBits+1)'(win_q[1]) + (SampleBits+1)'(win_q[7]);
  assign plus_sum = (SampleBits+2)'(hor_sum) + (SampleBits+2)'(ver_sum);
  assign diag_sum = (SampleBits+2)'(win_q[0]) + (SampleBits+2)'(win_q[2])
                  + (SampleBits+2)'(win_q[6]) + (SampleBits+2)'(win_q[8]);

  assign push_o          = v2_q;
  assign entry_o.ctr     = win_q[4];
  assign entry_o.hor     = hor_sum[SampleBits:1];
  assign entry_o.ver     = ver_sum[SampleBits:1];
  assign entry_o.plus    = plus_sum[SampleBits+1:2];
  assign entry_o.diag    = diag_sum[SampleBits+1:2];
  assign entry_o.phase   = ph2_q;
  assign entry_o.row_end = re2_q;

  assign status_o.col = col_q;

endmodule

// ===== hw/rtl/bbd_queue.sv =====
// Short queue of finished pixel entries between front and back.
module bbd_queue import bbd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  pix_entry_t       entry_i,
  input  logic             pop_i,
  output pix_entry_t       entry_o,
  output logic [QCntW-1:0] count_o
);

  pix_entry_t       slots_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] count_q;

  always_ff @(posedge clk_i) begin
    if (push_i) slots_q[wr_ptr_q] <= entry_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + QPtrW'(1);
      if (pop_i)  rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      count_q <= count_q + QCntW'(push_i) - QCntW'(pop_i);
    end
  end

  assign entry_o = slots_q[rd_ptr_q];
  assign count_o = count_q;

endmodule

// ===== hw/rtl/bbd_back.sv =====
// Back end: colour selection by phase and the output register.
module bbd_back import bbd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  head_valid_i,
  input  pix_entry_t            entry_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [SampleBits-1:0] red_o,
  output logic [SampleBits-1:0] green_o,
  output logic [SampleBits-1:0] blue_o,
  output logic                  row_end_o
);

  logic                  out_valid_q, out_valid_d;
  logic [SampleBits-1:0] red_q, green_q, blue_q, red_d, green_d, blue_d;
  logic                  row_end_q;

  assign pop_o = head_valid_i && (!out_valid_q || !out_stall_i);

  always_comb begin
    unique case (entry_i.phase)
      PH_RED: begin
        red_d = entry_i.ctr;  green_d = entry_i.plus; blue_d = entry_i.diag;
      end
      PH_BLUE: begin
        red_d = entry_i.diag; green_d = entry_i.plus; blue_d = entry_i.ctr;
      end
      PH_GR_RROW: begin
        red_d = entry_i.hor;  green_d = entry_i.ctr;  blue_d = entry_i.ver;
      end
      default: begin
        red_d = entry_i.ver;  green_d = entry_i.ctr;  blue_d = entry_i.hor;
      end
    endcase
  end

  always_comb begin
    priority if (pop_o) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      red_q     <= red_d;
      green_q   <= green_d;
      blue_q    <= blue_d;
      row_end_q <= entry_i.row_end;
    end
  end

  assign out_valid_o = out_valid_q;
  assign red_o       = red_q;
  assign green_o     = green_q;
  assign blue_o      = blue_q;
  assign row_end_o   = row_end_q;

endmodule

// ===== hw/rtl/bayer_bilinear_demosaic_top.sv =====
// Top level of the 3x3 bilinear Bayer demosaic block.
//
//   channel | direction | handshake              | payload
//   in      | input     | in_valid_i/in_stall_o  | raw_sample_i, frame_start_i
//   out     | output    | out_valid_o/out_stall_i| red_o, green_o, blue_o, row_end_o
//   cfg     | input     | cfg_we_i               | cfg_idx_i, cfg_wdata_i
//
// One sample per cycle sustained unless the input is stalled; a result passes
// from its completing sample through the registered line store read, the window
// stage and the queue into the output register. Reset clears counters, window
// and queue; line stores are not cleared. Input stalls only when queue plus
// in-flight entries fill the eight-entry queue, i.e. after a sustained output
// stall.
`include "bayer_bilinear_demosaic_top_defines.svh"

module bayer_bilinear_demosaic_top import bbd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CfgIdxW-1:0]    cfg_idx_i,
  input  logic [CfgDataW-1:0]   cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [SampleBits-1:0] raw_sample_i,
  input  logic                  frame_start_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [SampleBits-1:0] red_o,
  output logic [SampleBits-1:0] green_o,
  output logic [SampleBits-1:0] blue_o,
  output logic                  row_end_o
);

  cfg_t          cfg_q;
  logic          q_push, q_pop;
  logic [QCntW-1:0] q_count;
  pix_entry_t    push_entry, head_entry;
  front_status_t front_st;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pattern      <= '0;
      cfg_q.line_width   <= LineWidthRst;
      cfg_q.frame_height <= FrameHeightRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegPattern:     cfg_q.pattern      <= cfg_wdata_i[1:0];
        RegLineWidth:   cfg_q.line_width   <= cfg_wdata_i[WidthW-1:0];
        RegFrameHeight: cfg_q.frame_height <= cfg_wdata_i[HeightW-1:0];
        default: ;
      endcase
    end
  end

  bbd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .in_valid_i    (in_valid_i),
    .raw_sample_i  (raw_sample_i),
    .frame_start_i (frame_start_i),
    .in_stall_o    (in_stall_o),
    .q_count_i     (q_count),
    .push_o        (q_push),
    .entry_o       (push_entry),
    .status_o      (front_st)
  );

  bbd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (push_entry),
    .pop_i   (q_pop),
    .entry_o (head_entry),
    .count_o (q_count)
  );

  bbd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (q_count != '0),
    .entry_i      (head_entry),
    .pop_o        (q_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .red_o        (red_o),
    .green_o      (green_o),
    .blue_o       (blue_o),
    .row_end_o    (row_end_o)
  );

  `BBD_ASSERT(a_queue_no_overflow, clk_i, rst_ni, q_push |-> (q_count != QCntW'(QDepth)))
  `BBD_ASSERT_NEVER(a_no_pop_empty, clk_i, rst_ni, q_pop && (q_count == '0))
  `BBD_ASSERT(a_out_from_queue, clk_i, rst_ni, $rose(out_valid_o) |-> $past(q_pop))
  `BBD_ASSERT(a_frame_start_col, clk_i, rst_ni, (in_valid_i && !in_stall_o && frame_start_i) |=> (front_st.col == AddrW'(1)))

endmodule
